@@ src/flt_pkg.sv @@
// ----------------------------------------------------------------------------
// flt_pkg
// Shared constants, codes and types for the file lock table.
// ----------------------------------------------------------------------------
package flt_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int INODE_BITS_DEF    = 16;
    localparam int PID_BITS_DEF      = 8;

    // Fixed field widths
    localparam int KIND_BITS   = 2;
    localparam int WHENCE_BITS = 2;
    localparam int RANGE_BITS  = 32;

    // Command codes
    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_SET   = 1'b1;

    // Lock kind codes
    localparam logic [KIND_BITS-1:0] KIND_READ     = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_WRITE    = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_UNLOCK   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_UNLOCKED = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_INVALID  = 2'd3;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } flt_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // capture the request, restart the scan
        logic scan;    // issue a table read and advance the index
        logic finish;  // decide, update the table, load the result
    } flt_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_last;  // index points at the last entry
        logic out_busy;   // result register holds an untaken result
    } flt_stat_t;

endpackage

@@ src/flt_ram.sv @@
// ----------------------------------------------------------------------------
// flt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module flt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/flt_ctrl.sv @@
// ----------------------------------------------------------------------------
// flt_ctrl
// Sequencer for one request: accept, scan every entry, drain, finish.
// ----------------------------------------------------------------------------
module flt_ctrl
    import flt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  flt_stat_t stat,
    output flt_cmd_t  cmd
);

    flt_state_t state_reg;
    flt_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the result register is free
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/flt_datapath.sv @@
// ----------------------------------------------------------------------------
// flt_datapath
// Request registers, entry scan with match and free-slot tracking, valid
// bits, record RAM and the result register.
// ----------------------------------------------------------------------------
module flt_datapath
    import flt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int INODE_BITS    = INODE_BITS_DEF,
    parameter int PID_BITS      = PID_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  flt_cmd_t               cmd,
    output flt_stat_t              stat,
    input  logic                   s_cmd,
    input  logic [INODE_BITS-1:0]  s_inode,
    input  logic [KIND_BITS-1:0]   s_lock_kind,
    input  logic [PID_BITS-1:0]    s_owner_pid,
    input  logic [WHENCE_BITS-1:0] s_whence,
    input  logic [RANGE_BITS-1:0]  s_range_start,
    input  logic [RANGE_BITS-1:0]  s_range_len,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_status,
    output logic [KIND_BITS-1:0]   m_held_kind,
    output logic [PID_BITS-1:0]    m_held_pid,
    output logic [WHENCE_BITS-1:0] m_held_whence,
    output logic [RANGE_BITS-1:0]  m_held_start,
    output logic [RANGE_BITS-1:0]  m_held_len
);

    localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LEN_LSB   = 0;
    localparam int START_LSB = LEN_LSB + RANGE_BITS;
    localparam int WH_LSB    = START_LSB + RANGE_BITS;
    localparam int KIND_LSB  = WH_LSB + WHENCE_BITS;
    localparam int PID_LSB   = KIND_LSB + 1;
    localparam int INO_LSB   = PID_LSB + PID_BITS;
    localparam int REC_W     = INO_LSB + INODE_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Request registers
    logic                   req_cmd_reg;
    logic [INODE_BITS-1:0]  req_inode_reg;
    logic [KIND_BITS-1:0]   req_kind_reg;
    logic [PID_BITS-1:0]    req_pid_reg;
    logic [WHENCE_BITS-1:0] req_whence_reg;
    logic [RANGE_BITS-1:0]  req_start_reg;
    logic [RANGE_BITS-1:0]  req_len_reg;

    // Scan state
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_en_reg;
    logic             found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // Copy of the matching record
    logic [PID_BITS-1:0]    hit_pid_reg;
    logic                   hit_kind_reg;
    logic [WHENCE_BITS-1:0] hit_whence_reg;
    logic [RANGE_BITS-1:0]  hit_start_reg;
    logic [RANGE_BITS-1:0]  hit_len_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg;

    // Result register
    logic                   m_valid_reg;
    logic                   out_status_reg;
    logic [KIND_BITS-1:0]   out_kind_reg;
    logic [PID_BITS-1:0]    out_pid_reg;
    logic [WHENCE_BITS-1:0] out_whence_reg;
    logic [RANGE_BITS-1:0]  out_start_reg;
    logic [RANGE_BITS-1:0]  out_len_reg;

    logic [REC_W-1:0] rd_data;
    logic [REC_W-1:0] wr_data;
    logic             entry_hit;
    logic             entry_free;
    logic             is_lock;
    logic             lock_ok;
    logic             unlock_ok;

    // Record store
    assign wr_data = {req_inode_reg, req_pid_reg, req_kind_reg[0], req_whence_reg,
                      req_start_reg, req_len_reg};

    flt_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.finish && lock_ok),
        .wr_addr (free_idx_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.scan),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    // Compare the entry read in the previous cycle
    assign entry_hit  = cmp_en_reg && !found_reg && valid_reg[cmp_idx_reg]
                        && (rd_data[INO_LSB +: INODE_BITS] == req_inode_reg);
    assign entry_free = cmp_en_reg && !free_found_reg && !valid_reg[cmp_idx_reg];

    // Decide the request outcome
    assign is_lock   = (req_cmd_reg == CMD_SET)
                       && (req_kind_reg == KIND_READ || req_kind_reg == KIND_WRITE);
    assign lock_ok   = is_lock && !found_reg && free_found_reg;
    assign unlock_ok = (req_cmd_reg == CMD_SET) && (req_kind_reg == KIND_UNLOCK)
                       && found_reg && (hit_pid_reg == req_pid_reg);

    assign stat.scan_last = (scan_idx_reg == LAST_IDX);
    assign stat.out_busy  = m_valid_reg && !m_ready;

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_cmd_reg    <= s_cmd;
            req_inode_reg  <= s_inode;
            req_kind_reg   <= s_lock_kind;
            req_pid_reg    <= s_owner_pid;
            req_whence_reg <= s_whence;
            req_start_reg  <= s_range_start;
            req_len_reg    <= s_range_len;
        end
    end

    // Advance the scan and track first match and first free slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg   <= '0;
            cmp_idx_reg    <= '0;
            cmp_en_reg     <= 1'b0;
            found_reg      <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end else begin
            cmp_en_reg  <= cmd.scan;
            cmp_idx_reg <= scan_idx_reg;
            if (cmd.load) begin
                scan_idx_reg   <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else begin
                if (cmd.scan && !stat.scan_last) begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (entry_hit) begin
                    found_reg   <= 1'b1;
                    hit_idx_reg <= cmp_idx_reg;
                end
                if (entry_free) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= cmp_idx_reg;
                end
            end
        end
    end

    // Hold the matching record
    always_ff @(posedge aclk) begin
        if (entry_hit) begin
            hit_pid_reg    <= rd_data[PID_LSB +: PID_BITS];
            hit_kind_reg   <= rd_data[KIND_LSB];
            hit_whence_reg <= rd_data[WH_LSB +: WHENCE_BITS];
            hit_start_reg  <= rd_data[START_LSB +: RANGE_BITS];
            hit_len_reg    <= rd_data[LEN_LSB +: RANGE_BITS];
        end
    end

    // Set or drop valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.finish) begin
            if (lock_ok) begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (unlock_ok) begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    // Result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_kind_reg   <= '0;
            out_pid_reg    <= '0;
            out_whence_reg <= '0;
            out_start_reg  <= '0;
            out_len_reg    <= '0;
            if (req_cmd_reg == CMD_QUERY) begin
                out_status_reg <= STATUS_OK;
                if (found_reg) begin
                    out_kind_reg   <= {1'b0, hit_kind_reg};
                    out_pid_reg    <= hit_pid_reg;
                    out_whence_reg <= hit_whence_reg;
                    out_start_reg  <= hit_start_reg;
                    out_len_reg    <= hit_len_reg;
                end else begin
                    out_kind_reg <= KIND_UNLOCKED;
                end
            end else begin
                out_status_reg <= (lock_ok || unlock_ok) ? STATUS_OK : STATUS_FAIL;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_status_reg;
    assign m_held_kind   = out_kind_reg;
    assign m_held_pid    = out_pid_reg;
    assign m_held_whence = out_whence_reg;
    assign m_held_start  = out_start_reg;
    assign m_held_len    = out_len_reg;

endmodule

@@ src/file_lock_table.sv @@
// ----------------------------------------------------------------------------
// file_lock_table
// Whole-file advisory lock table keyed by inode, with query, lock and unlock.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel (valid/ready); each transfer carries a
//   command, inode, lock kind, owner pid, whence and range. Every request
//   gives exactly one result transfer on the m_ channel: a status and, for a
//   query, the stored lock record (kind unlocked when no entry matches).
//   A request scans all TABLE_ENTRIES entries one per cycle through the
//   record RAM read port; a new request is accepted only once the sequencer
//   has finished the previous one and returned to idle.
//   The result sits in an output register; the next request is accepted and
//   scanned while it waits. If the receiver stalls, the following request
//   holds in its final step until the result register is free.
//   Reset (aresetn low, synchronous) clears every entry's valid bit at once,
//   empties the result register and returns the sequencer to idle; record
//   contents are not cleared, as they are read only behind a valid bit.
// ----------------------------------------------------------------------------
module file_lock_table
    import flt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int INODE_BITS    = INODE_BITS_DEF,
    parameter int PID_BITS      = PID_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_cmd,
    input  logic [INODE_BITS-1:0]  s_inode,
    input  logic [KIND_BITS-1:0]   s_lock_kind,
    input  logic [PID_BITS-1:0]    s_owner_pid,
    input  logic [WHENCE_BITS-1:0] s_whence,
    input  logic [RANGE_BITS-1:0]  s_range_start,
    input  logic [RANGE_BITS-1:0]  s_range_len,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_status,
    output logic [KIND_BITS-1:0]   m_held_kind,
    output logic [PID_BITS-1:0]    m_held_pid,
    output logic [WHENCE_BITS-1:0] m_held_whence,
    output logic [RANGE_BITS-1:0]  m_held_start,
    output logic [RANGE_BITS-1:0]  m_held_len
);

    flt_cmd_t  cmd;
    flt_stat_t stat;

    // Sequencer
    flt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Table and result datapath
    flt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .INODE_BITS    (INODE_BITS),
        .PID_BITS      (PID_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_cmd         (s_cmd),
        .s_inode       (s_inode),
        .s_lock_kind   (s_lock_kind),
        .s_owner_pid   (s_owner_pid),
        .s_whence      (s_whence),
        .s_range_start (s_range_start),
        .s_range_len   (s_range_len),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_held_kind   (m_held_kind),
        .m_held_pid    (m_held_pid),
        .m_held_whence (m_held_whence),
        .m_held_start  (m_held_start),
        .m_held_len    (m_held_len)
    );

endmodule

@@ tb/sv/flt_lock_checker.sv @@
// ----------------------------------------------------------------------------
// flt_lock_checker
// Watches both channels of the file lock table, keeps a shadow copy of the
// lock records, predicts one reply per accepted request and compares every
// reply field by field, in order.
// ----------------------------------------------------------------------------
module flt_lock_checker
    import flt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int INODE_BITS    = INODE_BITS_DEF,
    parameter int PID_BITS      = PID_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic                   s_cmd,
    input  logic [INODE_BITS-1:0]  s_inode,
    input  logic [KIND_BITS-1:0]   s_lock_kind,
    input  logic [PID_BITS-1:0]    s_owner_pid,
    input  logic [WHENCE_BITS-1:0] s_whence,
    input  logic [RANGE_BITS-1:0]  s_range_start,
    input  logic [RANGE_BITS-1:0]  s_range_len,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic                   m_status,
    input  logic [KIND_BITS-1:0]   m_held_kind,
    input  logic [PID_BITS-1:0]    m_held_pid,
    input  logic [WHENCE_BITS-1:0] m_held_whence,
    input  logic [RANGE_BITS-1:0]  m_held_start,
    input  logic [RANGE_BITS-1:0]  m_held_len,
    input  logic                   drain_done,
    output int                     fail_count,
    output int                     pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                   status;
        logic [KIND_BITS-1:0]   kind;
        logic [PID_BITS-1:0]    pid;
        logic [WHENCE_BITS-1:0] whence;
        logic [RANGE_BITS-1:0]  start;
        logic [RANGE_BITS-1:0]  len;
    } lock_reply_t;

    // Shadow lock records
    logic                   rec_valid  [TABLE_ENTRIES];
    logic [INODE_BITS-1:0]  rec_inode  [TABLE_ENTRIES];
    logic [PID_BITS-1:0]    rec_pid    [TABLE_ENTRIES];
    logic                   rec_write  [TABLE_ENTRIES];
    logic [WHENCE_BITS-1:0] rec_whence [TABLE_ENTRIES];
    logic [RANGE_BITS-1:0]  rec_start  [TABLE_ENTRIES];
    logic [RANGE_BITS-1:0]  rec_len    [TABLE_ENTRIES];

    lock_reply_t expected_replies[$];
    int          reply_index = 0;
    bit          leftover_checked = 1'b0;

    task automatic report_error(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string fname, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("reply %0d %s: got %0h, want %0h",
                                   reply_index, fname, got, want));
        end
    endtask

    // Lowest valid record holding the inode, -1 if none
    function automatic int find_inode(input logic [INODE_BITS-1:0] ino);
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (rec_valid[k] && rec_inode[k] == ino) return k;
        end
        return -1;
    endfunction

    // Lowest free record, -1 if the table is full
    function automatic int find_free();
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (!rec_valid[k]) return k;
        end
        return -1;
    endfunction

    // Apply one request to the shadow table and return its reply
    function automatic lock_reply_t apply_request(
        input logic                   cmd,
        input logic [INODE_BITS-1:0]  ino,
        input logic [KIND_BITS-1:0]   kind,
        input logic [PID_BITS-1:0]    pid,
        input logic [WHENCE_BITS-1:0] whence,
        input logic [RANGE_BITS-1:0]  start,
        input logic [RANGE_BITS-1:0]  len
    );
        lock_reply_t r;
        int          hit;
        int          slot;
        r        = '{default: '0};
        r.status = STATUS_FAIL;
        hit      = find_inode(ino);
        if (cmd == CMD_QUERY) begin
            r.status = STATUS_OK;
            if (hit >= 0) begin
                r.kind   = rec_write[hit] ? KIND_WRITE : KIND_READ;
                r.pid    = rec_pid[hit];
                r.whence = rec_whence[hit];
                r.start  = rec_start[hit];
                r.len    = rec_len[hit];
            end else begin
                r.kind = KIND_UNLOCKED;
            end
        end else if (kind == KIND_READ || kind == KIND_WRITE) begin
            // a lock on a locked inode fails and leaves the table alone
            slot = find_free();
            if (hit < 0 && slot >= 0) begin
                rec_valid[slot]  = 1'b1;
                rec_inode[slot]  = ino;
                rec_pid[slot]    = pid;
                rec_write[slot]  = (kind == KIND_WRITE);
                rec_whence[slot] = whence;
                rec_start[slot]  = start;
                rec_len[slot]    = len;
                r.status         = STATUS_OK;
            end
        end else if (kind == KIND_UNLOCK) begin
            // only the owner may release
            if (hit >= 0 && rec_pid[hit] == pid) begin
                rec_valid[hit] = 1'b0;
                r.status       = STATUS_OK;
            end
        end
        return r;
    endfunction

    // Match replies against the oldest prediction, then predict new requests
    always @(posedge aclk) begin : watch
        lock_reply_t want;
        if (!aresetn) begin
            foreach (rec_valid[k]) rec_valid[k] = 1'b0;
            expected_replies.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    report_error($sformatf("reply %0d with no request outstanding",
                                           reply_index));
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", 32'(m_status), 32'(want.status));
                    check_field("held_kind", 32'(m_held_kind), 32'(want.kind));
                    check_field("held_pid", 32'(m_held_pid), 32'(want.pid));
                    check_field("held_whence", 32'(m_held_whence), 32'(want.whence));
                    check_field("held_start", m_held_start, want.start);
                    check_field("held_len", m_held_len, want.len);
                end
                reply_index++;
            end
            if (s_valid && s_ready) begin
                expected_replies.push_back(apply_request(s_cmd, s_inode, s_lock_kind,
                    s_owner_pid, s_whence, s_range_start, s_range_len));
            end
            if (drain_done && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (expected_replies.size() != 0) begin
                    report_error($sformatf("%0d replies never arrived",
                                           expected_replies.size()));
                end
            end
        end
        pending_count <= expected_replies.size();
    end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Request traffic for the file lock table: a directed pass over the corner
// cases, then random lock, unlock and query sequences on a small inode pool
// with bursty requests, a stalling receiver and one long back-pressure spell.
// ----------------------------------------------------------------------------
module tb;
    import flt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INODE_W       = INODE_BITS_DEF;
    localparam int PID_W         = PID_BITS_DEF;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int POOL_SIZE     = 24;
    localparam int PID_POOL      = 4;
    localparam int HOLD_OFF_AT   = 500;
    localparam int HOLD_OFF_LEN  = 400;
    localparam int DRAIN_CYCLES  = 3 * (TABLE_ENTRIES_DEF + 3);
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct {
        logic                   cmd;
        logic [INODE_W-1:0]     inode;
        logic [KIND_BITS-1:0]   kind;
        logic [PID_W-1:0]       pid;
        logic [WHENCE_BITS-1:0] whence;
        logic [RANGE_BITS-1:0]  start;
        logic [RANGE_BITS-1:0]  len;
    } lock_req_t;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic                   s_cmd         = CMD_QUERY;
    logic [INODE_W-1:0]     s_inode       = '0;
    logic [KIND_BITS-1:0]   s_lock_kind   = KIND_READ;
    logic [PID_W-1:0]       s_owner_pid   = '0;
    logic [WHENCE_BITS-1:0] s_whence      = '0;
    logic [RANGE_BITS-1:0]  s_range_start = '0;
    logic [RANGE_BITS-1:0]  s_range_len   = '0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic                   m_status;
    logic [KIND_BITS-1:0]   m_held_kind;
    logic [PID_W-1:0]       m_held_pid;
    logic [WHENCE_BITS-1:0] m_held_whence;
    logic [RANGE_BITS-1:0]  m_held_start;
    logic [RANGE_BITS-1:0]  m_held_len;
    logic                   drain_done    = 1'b0;
    int                     fail_count;
    int                     pending_count;
    int                     cycle_count   = 0;

    bit                     hold_off_req  = 1'b0;
    bit                     lock_heavy    = 1'b0;
    int                     burst_left    = 0;
    logic [INODE_W-1:0]     inode_pool  [POOL_SIZE];
    logic [PID_W-1:0]       pid_pool    [PID_POOL];
    logic [PID_W-1:0]       owner_hint  [POOL_SIZE];

    file_lock_table u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_inode       (s_inode),
        .s_lock_kind   (s_lock_kind),
        .s_owner_pid   (s_owner_pid),
        .s_whence      (s_whence),
        .s_range_start (s_range_start),
        .s_range_len   (s_range_len),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_held_kind   (m_held_kind),
        .m_held_pid    (m_held_pid),
        .m_held_whence (m_held_whence),
        .m_held_start  (m_held_start),
        .m_held_len    (m_held_len)
    );

    flt_lock_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_inode       (s_inode),
        .s_lock_kind   (s_lock_kind),
        .s_owner_pid   (s_owner_pid),
        .s_whence      (s_whence),
        .s_range_start (s_range_start),
        .s_range_len   (s_range_len),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_held_kind   (m_held_kind),
        .m_held_pid    (m_held_pid),
        .m_held_whence (m_held_whence),
        .m_held_start  (m_held_start),
        .m_held_len    (m_held_len),
        .drain_done    (drain_done),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 4 ns clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic lock_req_t mk_req(
        input logic                   cmd,
        input logic [INODE_W-1:0]     inode,
        input logic [KIND_BITS-1:0]   kind,
        input logic [PID_W-1:0]       pid,
        input logic [WHENCE_BITS-1:0] whence,
        input logic [RANGE_BITS-1:0]  start,
        input logic [RANGE_BITS-1:0]  len
    );
        lock_req_t r;
        r.cmd    = cmd;
        r.inode  = inode;
        r.kind   = kind;
        r.pid    = pid;
        r.whence = whence;
        r.start  = start;
        r.len    = len;
        return r;
    endfunction

    // Mostly well-formed lock traffic on the pool, with some raw noise
    function automatic lock_req_t random_request();
        lock_req_t r;
        int        slot;
        int        pick;
        slot     = $urandom_range(0, POOL_SIZE - 1);
        r.inode  = inode_pool[slot];
        r.pid    = pid_pool[$urandom_range(0, PID_POOL - 1)];
        r.whence = WHENCE_BITS'($urandom_range(0, 3));
        r.start  = $urandom();
        r.len    = $urandom();
        r.kind   = KIND_BITS'($urandom_range(0, 3));
        pick     = $urandom_range(0, 99);
        if (pick < 10) begin
            r.cmd   = 1'($urandom_range(0, 1));
            r.inode = INODE_W'($urandom_range(0, 65535));
            r.pid   = PID_W'($urandom_range(0, 255));
        end else if (pick < 35) begin
            r.cmd = CMD_QUERY;
        end else if (pick < (lock_heavy ? 82 : 55)) begin
            r.cmd  = CMD_SET;
            r.kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
            owner_hint[slot] = r.pid;
        end else if (pick < 97) begin
            // release, usually by the last pid that asked for this inode
            r.cmd  = CMD_SET;
            r.kind = KIND_UNLOCK;
            if ($urandom_range(0, 4) != 0) r.pid = owner_hint[slot];
        end else begin
            r.cmd  = CMD_SET;
            r.kind = KIND_INVALID;
        end
        return r;
    endfunction

    // Offer one request and hold it until the transfer
    task automatic send_request(input lock_req_t r);
        s_valid       <= 1'b1;
        s_cmd         <= r.cmd;
        s_inode       <= r.inode;
        s_lock_kind   <= r.kind;
        s_owner_pid   <= r.pid;
        s_whence      <= r.whence;
        s_range_start <= r.start;
        s_range_len   <= r.len;
        do @(posedge aclk); while (!s_ready);
        // end of a burst: drop valid for a random gap
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : int'($urandom_range(0, 24));
        end
    endtask

    // Receiver: stall patterns in random segments, one long hold-off
    initial begin : receiver
        int seg_len;
        int mode;
        @(posedge aclk);
        forever begin
            seg_len = $urandom_range(1, 48);
            mode    = $urandom_range(0, 3);
            for (int i = 0; i < seg_len; i++) begin
                @(posedge aclk);
                if (hold_off_req) begin
                    hold_off_req = 1'b0;
                    m_ready <= 1'b0;
                    repeat (HOLD_OFF_LEN) @(posedge aclk);
                end
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) == 0);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty lookup, extremes of every field, each failure path
        send_request(mk_req(CMD_QUERY, 16'h0000, KIND_INVALID, 8'h00, 2'd0, '0, '0));
        send_request(mk_req(CMD_SET, 16'h0000, KIND_READ, 8'h00, 2'd0, '0, '0));
        send_request(mk_req(CMD_SET, 16'hFFFF, KIND_WRITE, 8'hFF, 2'd3, '1, '1));
        send_request(mk_req(CMD_QUERY, 16'h0000, KIND_READ, 8'hFF, 2'd3, '1, '1));
        send_request(mk_req(CMD_QUERY, 16'hFFFF, KIND_UNLOCK, 8'h00, 2'd0, '0, '0));
        send_request(mk_req(CMD_SET, 16'h0000, KIND_WRITE, 8'h05, 2'd1, 32'h10, 32'h20));
        send_request(mk_req(CMD_SET, 16'h1234, KIND_INVALID, 8'h11, 2'd2, 32'h1, 32'h2));
        send_request(mk_req(CMD_SET, 16'h0000, KIND_UNLOCK, 8'h07, 2'd0, '0, '0));
        send_request(mk_req(CMD_SET, 16'h4321, KIND_UNLOCK, 8'h00, 2'd0, '0, '0));
        // fill the table, then one lock too many
        for (int i = 0; i < TABLE_ENTRIES_DEF - 2; i++) begin
            send_request(mk_req(CMD_SET, 16'h0100 + 16'(i), (i % 2) ? KIND_WRITE : KIND_READ,
                                8'(i), 2'(i), $urandom(), $urandom()));
        end
        send_request(mk_req(CMD_SET, 16'hBEEF, KIND_WRITE, 8'h42, 2'd2, '1, '0));
        send_request(mk_req(CMD_SET, 16'h0000, KIND_UNLOCK, 8'h00, 2'd0, '0, '0));
        send_request(mk_req(CMD_QUERY, 16'h0000, KIND_READ, 8'h00, 2'd0, '0, '0));

        // Random sequences; refresh the pools now and then, swing the mix
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 250 == 0) begin
                foreach (inode_pool[i]) inode_pool[i] = INODE_W'($urandom_range(0, 65535));
                foreach (pid_pool[i]) pid_pool[i] = PID_W'($urandom_range(0, 255));
                foreach (owner_hint[i]) owner_hint[i] = pid_pool[0];
            end
            if (n % 125 == 0) lock_heavy = ~lock_heavy;
            // keep offering through the receiver hold-off so the block backs up
            if (n == HOLD_OFF_AT) begin
                hold_off_req = 1'b1;
                burst_left   = 600;
            end
            send_request(random_request());
        end
        s_valid <= 1'b0;

        // Drain
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        drain_done <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/flt_pkg.sv
src/flt_ram.sv
src/flt_ctrl.sv
src/flt_datapath.sv
src/file_lock_table.sv
tb/sv/flt_lock_checker.sv
tb/sv/tb.sv
